// ----- rtl/atcs_pkg.sv -----
// Shared types, register codes and the control program of the adaptive smoother.
// Used by atcs_useq, atcs_dpath and adaptive_time_constant_smoother.
package atcs_pkg;

    localparam int DEF_FRACTION_BITS    = 16;
    localparam int DEF_ELAPSED_LIMIT_MS = 1000;

    localparam int SMP_W   = 16;   // sample width
    localparam int ELA_W   = 16;   // elapsed_ms width
    localparam int TC_W    = 16;   // time constant width
    localparam int FD_W    = 24;   // jump threshold width
    localparam int CFG_IW  = 2;    // register index width
    localparam int CFG_DW  = 24;   // register write data width
    localparam int STEP_W  = 5;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_BASE_TIME = 2'd0;
    localparam logic [CFG_IW-1:0] REG_FAST_TIME = 2'd1;
    localparam logic [CFG_IW-1:0] REG_FAST_DLT  = 2'd2;
    localparam logic [CFG_IW-1:0] REG_ZERO_TIME = 2'd3;

    localparam logic [TC_W-1:0] RST_BASE_TIME = 16'd650;
    localparam logic [TC_W-1:0] RST_FAST_TIME = 16'd180;
    localparam logic [FD_W-1:0] RST_FAST_DLT  = 24'd179200;
    localparam logic [TC_W-1:0] RST_ZERO_TIME = 16'd300;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_DIFF,       // form |target - value|, direction, default time constant
        OP_MUL_SPAN,   // start multiply of d by (base - fast)
        OP_MUL_DT,     // start multiply of d by dt
        OP_MUL_STEP,   // one shift-add bit
        OP_DIV_DD,     // start divide by scaled jump threshold, 16 quotient bits
        OP_DIV_TC,     // start divide by tc, full-width quotient
        OP_DIV_STEP,   // one restoring bit
        OP_TC_BLEND,   // tc = base - ceil(quotient)
        OP_TC_FAST,
        OP_ADD_HALF,   // add tc/2 for rounding
        OP_APPLY,      // move value toward target
        OP_SEED,       // value = target
        OP_EMIT        // hand result to the output register
    } t_op;

    typedef enum logic [3:0] {
        C_NONE,
        C_ALWAYS,
        C_IN_VALID,
        C_SEED,
        C_NO_FAST,
        C_BIG,
        C_CNT_NZ,
        C_ALPHA1,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;     // stay on this step while the condition is false
        t_step target;
    } t_cword;

    typedef struct packed {
        logic seed;      // not seeded yet or restart requested
        logic no_fast;   // fast/blend selection does not apply
        logic big;       // jump reaches the jump threshold
        logic cnt_nz;
        logic alpha1;    // tc is 0 or dt >= tc
    } t_dstat;

    // program step addresses
    localparam t_step S_IDLE   = 5'd0;
    localparam t_step S_DIFF   = 5'd1;
    localparam t_step S_SELF   = 5'd2;
    localparam t_step S_CMP    = 5'd3;
    localparam t_step S_MSPAN  = 5'd4;
    localparam t_step S_MLOOP1 = 5'd5;
    localparam t_step S_DDD    = 5'd6;
    localparam t_step S_DLOOP1 = 5'd7;
    localparam t_step S_BLEND  = 5'd8;
    localparam t_step S_FAST   = 5'd9;
    localparam t_step S_UPD    = 5'd10;
    localparam t_step S_MDT    = 5'd11;
    localparam t_step S_MLOOP2 = 5'd12;
    localparam t_step S_HALF   = 5'd13;
    localparam t_step S_DTC    = 5'd14;
    localparam t_step S_DLOOP2 = 5'd15;
    localparam t_step S_APPLY  = 5'd16;
    localparam t_step S_SEEDV  = 5'd17;
    localparam t_step S_EMIT   = 5'd18;

    function automatic t_cword mk_cw(input t_op op, input t_cond cond,
                                     input logic hold, input t_step target);
        t_cword w;
        w.op     = op;
        w.cond   = cond;
        w.hold   = hold;
        w.target = target;
        return w;
    endfunction

    function automatic t_cword ucode_rom(input t_step step);
        t_cword w;
        case (step)
            S_IDLE:   w = mk_cw(OP_NOP,      C_IN_VALID, 1'b1, S_DIFF);
            S_DIFF:   w = mk_cw(OP_DIFF,     C_SEED,     1'b0, S_SEEDV);
            S_SELF:   w = mk_cw(OP_NOP,      C_NO_FAST,  1'b0, S_UPD);
            S_CMP:    w = mk_cw(OP_NOP,      C_BIG,      1'b0, S_FAST);
            S_MSPAN:  w = mk_cw(OP_MUL_SPAN, C_NONE,     1'b0, S_IDLE);
            S_MLOOP1: w = mk_cw(OP_MUL_STEP, C_CNT_NZ,   1'b0, S_MLOOP1);
            S_DDD:    w = mk_cw(OP_DIV_DD,   C_NONE,     1'b0, S_IDLE);
            S_DLOOP1: w = mk_cw(OP_DIV_STEP, C_CNT_NZ,   1'b0, S_DLOOP1);
            S_BLEND:  w = mk_cw(OP_TC_BLEND, C_ALWAYS,   1'b0, S_UPD);
            S_FAST:   w = mk_cw(OP_TC_FAST,  C_NONE,     1'b0, S_IDLE);
            S_UPD:    w = mk_cw(OP_NOP,      C_ALPHA1,   1'b0, S_SEEDV);
            S_MDT:    w = mk_cw(OP_MUL_DT,   C_NONE,     1'b0, S_IDLE);
            S_MLOOP2: w = mk_cw(OP_MUL_STEP, C_CNT_NZ,   1'b0, S_MLOOP2);
            S_HALF:   w = mk_cw(OP_ADD_HALF, C_NONE,     1'b0, S_IDLE);
            S_DTC:    w = mk_cw(OP_DIV_TC,   C_NONE,     1'b0, S_IDLE);
            S_DLOOP2: w = mk_cw(OP_DIV_STEP, C_CNT_NZ,   1'b0, S_DLOOP2);
            S_APPLY:  w = mk_cw(OP_APPLY,    C_ALWAYS,   1'b0, S_EMIT);
            S_SEEDV:  w = mk_cw(OP_SEED,     C_NONE,     1'b0, S_IDLE);
            S_EMIT:   w = mk_cw(OP_EMIT,     C_OUT_FREE, 1'b1, S_IDLE);
            default:  w = mk_cw(OP_NOP,      C_ALWAYS,   1'b0, S_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/atcs_useq.sv -----
// Step counter and control-word fetch for the smoother program.
// Depends on atcs_pkg (program table, condition codes, status struct).
module atcs_useq
    import atcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_out_free,
    input  t_dstat i_stat,
    output t_cword o_cw,
    output logic   o_idle
);

    t_step  r_step;
    t_step  n_step;
    t_cword w_cw;
    logic   w_take;

    assign w_cw   = ucode_rom(r_step);
    assign o_cw   = w_cw;
    assign o_idle = (r_step == S_IDLE);

    always_comb begin
        case (w_cw.cond)
            C_NONE:     w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_IN_VALID: w_take = i_in_valid;
            C_SEED:     w_take = i_stat.seed;
            C_NO_FAST:  w_take = i_stat.no_fast;
            C_BIG:      w_take = i_stat.big;
            C_CNT_NZ:   w_take = i_stat.cnt_nz;
            C_ALPHA1:   w_take = i_stat.alpha1;
            C_OUT_FREE: w_take = i_out_free;
            default:    w_take = 1'b0;
        endcase
    end

    always_comb begin
        if (w_take) begin
            n_step = w_cw.target;
        end else if (w_cw.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ----- rtl/atcs_dpath.sv -----
// Datapath of the smoother: filter state, shift-add multiplier, restoring divider.
// Depends on atcs_pkg; driven one control word per cycle by atcs_useq.
module atcs_dpath
    import atcs_pkg::*;
#(
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS,
    parameter int ELAPSED_LIMIT_MS = DEF_ELAPSED_LIMIT_MS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [SMP_W-1:0] i_sample,
    input  logic [ELA_W-1:0] i_elapsed_ms,
    input  logic             i_restart,
    input  logic [TC_W-1:0]  i_base_time,
    input  logic [TC_W-1:0]  i_fast_time,
    input  logic [FD_W-1:0]  i_jump_thresh,
    input  logic [TC_W-1:0]  i_zero_time,
    input  t_cword           i_cw,
    output t_dstat           o_stat,
    output logic [SMP_W-1:0] o_result
);

    localparam int VW = SMP_W + FRACTION_BITS;   // value width
    localparam int PW = VW + ELA_W;              // product / dividend width
    localparam int CW = $clog2(VW);
    localparam logic [ELA_W-1:0] LIMIT = ELA_W'(ELAPSED_LIMIT_MS);

    logic [SMP_W-1:0] r_sample;
    logic [ELA_W-1:0] r_dt;
    logic             r_restart;
    logic             r_seeded;
    logic [VW-1:0]    r_cur;
    logic [VW-1:0]    r_d;
    logic             r_rising;
    logic [TC_W-1:0]  r_tc;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_dsh;
    logic [TC_W-1:0]  r_mpl;
    logic [VW-1:0]    r_quo;
    logic [CW-1:0]    r_cnt;

    logic [VW-1:0]    w_target;
    logic [VW-1:0]    w_dd;
    logic             w_ge;
    logic [TC_W:0]    w_cut;
    logic [VW-1:0]    w_step;
    logic [VW:0]      w_round;

    assign w_target = VW'(r_sample) << FRACTION_BITS;
    assign w_dd     = VW'(i_jump_thresh) << (FRACTION_BITS - 8);
    assign w_ge     = (r_acc >= r_dsh);
    assign w_cut    = (TC_W+1)'(r_quo[TC_W-1:0]) + (TC_W+1)'(r_acc != '0);
    assign w_step   = (r_quo > r_d) ? r_d : r_quo;
    assign w_round  = (VW+1)'(r_cur) + ((VW+1)'(1) << (FRACTION_BITS - 1));

    assign o_result = (w_round[VW:FRACTION_BITS] > (SMP_W+1)'({SMP_W{1'b1}}))
                      ? {SMP_W{1'b1}} : w_round[VW-1:FRACTION_BITS];

    assign o_stat.seed    = !r_seeded || r_restart;
    assign o_stat.no_fast = (r_sample == '0) || (i_jump_thresh == '0)
                            || !(i_fast_time < r_tc);
    assign o_stat.big     = (r_d >= w_dd);
    assign o_stat.cnt_nz  = (r_cnt != '0);
    assign o_stat.alpha1  = (r_tc == '0) || (r_dt >= r_tc);

    // control state: filter value and seeded flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur    <= '0;
            r_seeded <= 1'b0;
        end else begin
            case (i_cw.op)
                OP_SEED: begin
                    r_cur    <= w_target;
                    r_seeded <= 1'b1;
                end
                OP_APPLY: begin
                    r_cur <= r_rising ? r_cur + w_step : r_cur - w_step;
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sample  <= i_sample;
            r_dt      <= (i_elapsed_ms > LIMIT) ? LIMIT : i_elapsed_ms;
            r_restart <= i_restart;
        end
        case (i_cw.op)
            OP_DIFF: begin
                r_rising <= (w_target >= r_cur);
                r_d      <= (w_target >= r_cur) ? w_target - r_cur : r_cur - w_target;
                r_tc     <= (r_sample == '0) ? i_zero_time : i_base_time;
            end
            OP_MUL_SPAN: begin
                r_acc <= '0;
                r_mpl <= i_base_time - i_fast_time;
                r_cnt <= CW'(TC_W - 1);
            end
            OP_MUL_DT: begin
                r_acc <= '0;
                r_mpl <= r_dt;
                r_cnt <= CW'(ELA_W - 1);
            end
            OP_MUL_STEP: begin
                r_acc <= {r_acc[PW-2:0], 1'b0} + (r_mpl[TC_W-1] ? PW'(r_d) : '0);
                r_mpl <= {r_mpl[TC_W-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
            end
            OP_DIV_DD: begin
                r_dsh <= PW'(w_dd) << (TC_W - 1);
                r_quo <= '0;
                r_cnt <= CW'(TC_W - 1);
            end
            OP_DIV_TC: begin
                r_dsh <= PW'(r_tc) << (VW - 1);
                r_quo <= '0;
                r_cnt <= CW'(VW - 1);
            end
            OP_DIV_STEP: begin
                if (w_ge) begin
                    r_acc <= r_acc - r_dsh;
                end
                r_quo <= {r_quo[VW-2:0], w_ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - CW'(1);
            end
            OP_TC_BLEND: r_tc  <= i_base_time - w_cut[TC_W-1:0];
            OP_TC_FAST:  r_tc  <= i_fast_time;
            OP_ADD_HALF: r_acc <= r_acc + PW'(r_tc >> 1);
            default: ;
        endcase
    end

endmodule

// ----- rtl/adaptive_time_constant_smoother.sv -----
// Top level of the adaptive time-constant smoother: stream ports, registers, output stage.
// Depends on atcs_pkg, atcs_useq and atcs_dpath.
//
// One sample in, one smoothed value out. A short control program (atcs_useq) steps a
// plain datapath (atcs_dpath) that holds a 16.F value and works through one shared
// shift-add multiplier and one restoring divider, one bit per cycle. An item that seeds
// the value goes straight to the emit step; when alpha reaches one the update skips the
// multiply by dt and the divide by tc. Otherwise the bit-serial 16-bit multiplies and
// the divides (16 and 16 + F quotient bits) set how long an item takes, longest when
// the constant is blended and shortest on the base or zero constant. The emit step
// holds for as long as the output register is full and not draining. One item is
// worked on at a time; the next sample is taken as soon as the program is back at its
// start, while the previous result may still wait in the output register. Registers
// are to be written through the cfg channel only while no item is in flight; the block
// itself does not enforce this. The channel is always ready.
module adaptive_time_constant_smoother
    import atcs_pkg::*;
#(
    parameter int FRACTION_BITS    = DEF_FRACTION_BITS,
    parameter int ELAPSED_LIMIT_MS = DEF_ELAPSED_LIMIT_MS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [31:0]       s_axis_tdata,   // [15:0] sample, [31:16] elapsed_ms
    input  logic              s_axis_tuser,   // [0] restart
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [SMP_W-1:0]  m_axis_tdata,   // [15:0] smoothed
    // register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    logic [TC_W-1:0]  r_base_time;
    logic [TC_W-1:0]  r_fast_time;
    logic [FD_W-1:0]  r_jump_thresh;
    logic [TC_W-1:0]  r_zero_time;
    logic             r_out_valid;
    logic [SMP_W-1:0] r_out_data;

    t_cword           w_cw;
    t_dstat           w_stat;
    logic             w_idle;
    logic             w_in_xfer;
    logic             w_out_free;
    logic [SMP_W-1:0] w_result;

    assign s_axis_tready = w_idle;
    assign w_in_xfer     = s_axis_tvalid && w_idle;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // configuration registers; data above a register's width is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_time   <= RST_BASE_TIME;
            r_fast_time   <= RST_FAST_TIME;
            r_jump_thresh <= RST_FAST_DLT;
            r_zero_time   <= RST_ZERO_TIME;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BASE_TIME: r_base_time   <= i_cfg_data[TC_W-1:0];
                REG_FAST_TIME: r_fast_time   <= i_cfg_data[TC_W-1:0];
                REG_FAST_DLT:  r_jump_thresh <= i_cfg_data[FD_W-1:0];
                REG_ZERO_TIME: r_zero_time   <= i_cfg_data[TC_W-1:0];
                default: ;
            endcase
        end
    end

    // output register: load on the emit step once the slot is free, drop after transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cw.op == OP_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_cw.op == OP_EMIT && w_out_free) begin
            r_out_data <= w_result;
        end
    end

    atcs_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_cw       (w_cw),
        .o_idle     (w_idle)
    );

    atcs_dpath #(
        .FRACTION_BITS    (FRACTION_BITS),
        .ELAPSED_LIMIT_MS (ELAPSED_LIMIT_MS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_in_xfer),
        .i_sample      (s_axis_tdata[15:0]),
        .i_elapsed_ms  (s_axis_tdata[31:16]),
        .i_restart     (s_axis_tuser),
        .i_base_time   (r_base_time),
        .i_fast_time   (r_fast_time),
        .i_jump_thresh (r_jump_thresh),
        .i_zero_time   (r_zero_time),
        .i_cw          (w_cw),
        .o_stat        (w_stat),
        .o_result      (w_result)
    );

endmodule
